@@ design/kwsub_pkg.sv @@
// Package for the keyword substitution cipher.
// Holds item types, function codes, the controller-to-datapath command
// and the letter decode helpers.
package kwsub_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned IdxW       = 5;

  localparam logic [IdxW-1:0] LastLetter = IdxW'(NumLetters - 1);

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_TEXT  = 2'd2;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       is_text;
  } out_item_t;

  typedef struct packed {
    logic            capture;
    logic            key_clear;
    logic            key_place;
    logic            fill_step;
    logic            fill_last;
    logic [IdxW-1:0] fill_idx;
    logic            rd_en;
    logic            rd_held;
    logic            load_out;
  } dp_cmd_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CharUpperA) && (c <= CharUpperZ);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CharLowerA) && (c <= CharLowerZ);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic logic [7:0] letter_base(input logic [7:0] c);
    return is_lower(c) ? CharLowerA : CharUpperA;
  endfunction

  // Index 0..25 for letters, 0 for everything else.
  function automatic logic [IdxW-1:0] letter_idx(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - letter_base(c);
    return is_letter(c) ? diff[IdxW-1:0] : '0;
  endfunction

endpackage

@@ design/kwsub_ctrl.sv @@
// Controller for the keyword substitution cipher.
// Sequences accept, alphabet fill, table read and result load.
// Depends on kwsub_pkg.
module kwsub_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_func,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               complete,
  output kwsub_pkg::dp_cmd_t cmd
);
  import kwsub_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [IdxW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || ((state_r == ST_EMIT) && out_free));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        cmd.fill_idx  = fill_cnt_r;
        if (fill_cnt_r == LastLetter) begin
          cmd.fill_last = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_held = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      cmd.capture   = 1'b1;
      cmd.rd_en     = 1'b1;
      cmd.key_clear = (in_func == FUNC_START);
      cmd.key_place = (in_func == FUNC_KEY);
      fill_cnt_nxt  = '0;
      state_nxt     = ((in_func == FUNC_TEXT) && !complete) ? ST_FILL : ST_EMIT;
    end
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/kwsub_dp.sv @@
// Datapath for the keyword substitution cipher.
// Holds the forward and inverse tables, the key state, the mode register,
// the held item and the result register. Depends on kwsub_pkg.
module kwsub_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  kwsub_pkg::in_item_t  in_data,
  input  kwsub_pkg::dp_cmd_t   cmd,
  output logic                 complete,
  output kwsub_pkg::out_item_t out_data
);
  import kwsub_pkg::*;

  logic [IdxW-1:0]       fwd_mem [NumLetters];
  logic [IdxW-1:0]       inv_mem [NumLetters];

  logic [NumLetters-1:0] used_r, used_nxt;
  logic [IdxW-1:0]       count_r, count_nxt;
  logic                  complete_r, complete_nxt;
  logic                  mode_r;
  in_item_t              item_r;
  logic [IdxW-1:0]       fwd_q_r, inv_q_r;
  out_item_t             out_r;

  logic [IdxW-1:0]       in_idx, held_idx, wr_idx, rd_addr, map_idx;
  logic                  room;
  logic                  place_key, place_fill, wr_en;
  out_item_t             result;

  assign in_idx   = letter_idx(in_data.char_in);
  assign held_idx = letter_idx(item_r.char_in);
  assign room     = (count_r < IdxW'(NumLetters));

  assign place_key  = cmd.key_place && !complete_r && is_letter(in_data.char_in) &&
                      !used_r[in_idx] && room;
  assign place_fill = cmd.fill_step && !used_r[cmd.fill_idx] && room;
  assign wr_en      = place_key || place_fill;
  assign wr_idx     = cmd.fill_step ? cmd.fill_idx : in_idx;
  assign rd_addr    = cmd.rd_held ? held_idx : in_idx;

  always_comb begin
    used_nxt     = used_r;
    count_nxt    = count_r;
    complete_nxt = complete_r;
    if (cmd.key_clear) begin
      used_nxt     = '0;
      count_nxt    = '0;
      complete_nxt = 1'b0;
    end else begin
      if (wr_en) begin
        used_nxt[wr_idx] = 1'b1;
        count_nxt        = count_r + 1'b1;
      end
      if (cmd.fill_last) begin
        complete_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      count_r    <= '0;
      complete_r <= 1'b0;
      mode_r     <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      count_r    <= count_nxt;
      complete_r <= complete_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_mem[count_r] <= wr_idx;
      inv_mem[wr_idx]  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      fwd_q_r <= fwd_mem[rd_addr];
      inv_q_r <= inv_mem[rd_addr];
    end
  end

  always_comb begin
    map_idx = mode_r ? inv_q_r : fwd_q_r;
    if (map_idx >= IdxW'(NumLetters)) begin
      map_idx = '0;
    end
    result = '0;
    if (item_r.func == FUNC_TEXT) begin
      result.is_text  = 1'b1;
      result.char_out = is_letter(item_r.char_in) ?
                        letter_base(item_r.char_in) + {3'b000, map_idx} :
                        item_r.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r <= result;
    end
  end

  assign complete = complete_r;
  assign out_data = out_r;

endmodule

@@ design/keyword_substitution_cipher.sv @@
// Top level of the keyword substitution cipher.
// Joins kwsub_ctrl and kwsub_dp; types from kwsub_pkg.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall    in_item_t  {func, char_in}
//   out_     output     out_valid/out_stall  out_item_t {char_out, is_text}
//   cfg_     input      cfg_wr_en            cfg_wr_data = decrypt_mode
//
// Key and ready text items pass through the held-item and table read registers,
// then the result register; one item per cycle while the output does not stall;
// the result register frees the input side. The first text item after a new key
// first runs the alphabet fill, which walks 26 letters through the single table
// write port, then rereads. Synchronous active-low reset clears key state and
// mode; tables are not cleared. A stalled output holds the result; one more item
// is taken and held, then the input stalls.
module keyword_substitution_cipher (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  kwsub_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kwsub_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);
  import kwsub_pkg::*;

  dp_cmd_t cmd;
  logic    complete;

  kwsub_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .complete  (complete),
    .cmd       (cmd)
  );

  kwsub_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .complete    (complete),
    .out_data    (out_data)
  );

endmodule
